// File: design/pmce_pkg.sv
package pmce_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int MAX_FAC_DEF    = 8;
	localparam int DIST_W_DEF     = 32;

	localparam int COST_W     = 48;
	localparam int PC_W       = 11;
	localparam int FC_W       = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	localparam logic [PC_W-1:0] PC_RESET = 11'd1024;
	localparam logic [FC_W-1:0] FC_RESET = 4'd5;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_EVAL  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACILITY_COUNT = 4'd1;

	// tag that rides along with each table access
	typedef struct packed {
		logic wr;
		logic first_f;
		logic last_f;
		logic last_p;
	} tag_t;

	typedef struct packed {
		logic start;
		logic empty_fin;
		logic clear_best;
	} acc_ctl_t;

	// entries of a triangular table over n points
	function automatic longint unsigned tri_depth(input int unsigned n);
		longint unsigned nl;
		nl = longint'(n);
		return (nl * (nl + 1)) / 2;
	endfunction

endpackage

// File: design/pmce_tri_addr.sv
module pmce_tri_addr
	import pmce_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_vld,
	input  tag_t                                         in_tag,
	input  logic [$clog2(MAX_POINTS)-1:0]                a,
	input  logic [$clog2(MAX_POINTS)-1:0]                b,
	output logic                                         out_vld,
	output tag_t                                         out_tag,
	output logic [$clog2(tri_depth(MAX_POINTS))-1:0]     addr
);

	localparam int PW  = $clog2(MAX_POINTS);
	localparam int PRW = 2 * PW + 1;
	localparam int AW  = $clog2(tri_depth(MAX_POINTS));

	logic [PW-1:0]  hi_w;
	logic [PW-1:0]  lo_w;
	logic [PW:0]    hi_p1_w;
	logic [PRW-1:0] prod_w;

	logic           vld_s1;
	tag_t           tag_s1;
	logic [PW-1:0]  lo_s1;
	logic [PRW-1:0] prod_s1;

	logic           vld_s2;
	tag_t           tag_s2;
	logic [AW-1:0]  addr_s2;

	// row is the larger index
	assign hi_w    = (a >= b) ? a : b;
	assign lo_w    = (a >= b) ? b : a;
	assign hi_p1_w = {1'b0, hi_w} + (PW+1)'(1);
	assign prod_w  = PRW'(hi_w) * PRW'(hi_p1_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		lo_s1   <= lo_w;
		prod_s1 <= prod_w;
		tag_s2  <= tag_s1;
		addr_s2 <= AW'(prod_s1 >> 1) + AW'(lo_s1);
	end

	assign out_vld = vld_s2;
	assign out_tag = tag_s2;
	assign addr    = addr_s2;

endmodule

// File: design/pmce_dist_mem.sv
module pmce_dist_mem
	import pmce_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int DIST_WIDTH = DIST_W_DEF
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [$clog2(tri_depth(MAX_POINTS))-1:0] waddr,
	input  logic [DIST_WIDTH-1:0]                    wdata,
	input  logic                                     re,
	input  logic [$clog2(tri_depth(MAX_POINTS))-1:0] raddr,
	output logic [DIST_WIDTH-1:0]                    rdata
);

	localparam longint unsigned DEPTH = tri_depth(MAX_POINTS);

	logic [DIST_WIDTH-1:0] mem_q [DEPTH];
	logic [DIST_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/pmce_accum.sv
module pmce_accum
	import pmce_pkg::*;
#(
	parameter int DIST_WIDTH = DIST_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acc_ctl_t              ctl,
	input  logic                  rd_vld,
	input  tag_t                  rd_tag,
	input  logic [DIST_WIDTH-1:0] rd_data,
	output logic                  done,
	output logic [COST_W-1:0]     cost,
	output logic                  improved,
	output logic [COST_W-1:0]     best_cost
);

	logic [DIST_WIDTH-1:0] min_q;
	logic [COST_W-1:0]     total_q;
	logic [COST_W-1:0]     best_q;
	logic                  fin_q;
	logic                  done_q;
	logic [COST_W-1:0]     cost_q;
	logic                  improved_q;
	logic [COST_W-1:0]     best_cost_q;

	logic [DIST_WIDTH-1:0] cur_min_w;
	logic [COST_W:0]       sum_w;
	logic [COST_W-1:0]     total_nxt_w;
	logic                  better_w;

	assign cur_min_w   = (rd_tag.first_f || rd_data < min_q) ? rd_data : min_q;
	assign sum_w       = {1'b0, total_q} + (COST_W+1)'(cur_min_w);
	// saturate at all ones
	assign total_nxt_w = sum_w[COST_W] ? {COST_W{1'b1}} : sum_w[COST_W-1:0];
	assign better_w    = total_q < best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			best_q <= {COST_W{1'b1}};
		end else begin
			done_q <= fin_q;
			if (ctl.start) begin
				fin_q <= ctl.empty_fin;
			end else if (rd_vld && rd_tag.last_f && rd_tag.last_p) begin
				fin_q <= 1'b1;
			end else begin
				fin_q <= 1'b0;
			end
			if (ctl.clear_best) begin
				best_q <= {COST_W{1'b1}};
			end else if (fin_q && better_w) begin
				best_q <= total_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			total_q <= '0;
		end else if (rd_vld && rd_tag.last_f) begin
			total_q <= total_nxt_w;
		end
		if (rd_vld) begin
			min_q <= cur_min_w;
		end
		if (fin_q) begin
			cost_q      <= total_q;
			improved_q  <= better_w;
			best_cost_q <= better_w ? total_q : best_q;
		end
	end

	assign done      = done_q;
	assign cost      = cost_q;
	assign improved  = improved_q;
	assign best_cost = best_cost_q;

endmodule

// File: design/p_median_cost_evaluator_core.sv
// channel   | direction | handshake                | beat
// ----------+-----------+--------------------------+--------------------------------------
// command   | in        | start & !busy            | mode, point_a, point_b,
//           |           |                          | distance_value, slot, facility_point
// result    | out       | done, one cycle          | cost, improved, best_cost
// config    | in        | cfg_valid & cfg_ready    | cfg_index, cfg_data
//
// Evaluate: point_count * facility_count table reads; the distance memory takes
// one read per cycle, so the product of the two counts sets how long busy stays high.
// Distance write: busy while the triangular address is formed.
// Set slot and clear best: taken while busy stays low.
// Reset: best cost all ones, point_count 1024, facility_count 5; table and slots
// hold nothing until written. Results cannot be stalled; done pulses for one cycle.
module p_median_cost_evaluator_core
	import pmce_pkg::*;
#(
	parameter int MAX_POINTS     = MAX_POINTS_DEF,
	parameter int MAX_FACILITIES = MAX_FAC_DEF,
	parameter int DIST_WIDTH     = DIST_W_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            mode,
	input  logic [9:0]            point_a,
	input  logic [9:0]            point_b,
	input  logic [31:0]           distance_value,
	input  logic [2:0]            slot,
	input  logic [9:0]            facility_point,
	output logic                  done,
	output logic [COST_W-1:0]     cost,
	output logic                  improved,
	output logic [COST_W-1:0]     best_cost,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW = $clog2(MAX_POINTS);
	localparam int SW = (MAX_FACILITIES > 1) ? $clog2(MAX_FACILITIES) : 1;
	localparam int AW = $clog2(tri_depth(MAX_POINTS));

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            state_nxt;
	logic [PC_W-1:0]       point_count_q;
	logic [FC_W-1:0]       facility_count_q;
	logic [PW-1:0]         slots_q [MAX_FACILITIES];
	logic [DIST_WIDTH-1:0] wdata_q;
	logic [PW-1:0]         p_q;
	logic [SW-1:0]         f_q;
	logic [PW-1:0]         np_last_q;
	logic [SW-1:0]         nf_last_q;

	logic [PW-1:0]         np_last_w;
	logic [SW-1:0]         nf_last_w;
	logic                  pair_ok_w;
	logic                  slot_ok_w;
	logic                  p_last_w;
	logic                  f_last_w;

	logic                  iss_vld;
	tag_t                  iss_tag;
	logic [PW-1:0]         iss_a;
	logic [PW-1:0]         iss_b;
	acc_ctl_t              acc_ctl;

	logic                  tri_vld;
	tag_t                  tri_tag;
	logic [AW-1:0]         tri_addr;

	logic [DIST_WIDTH-1:0] rd_data;
	logic                  vld_s3;
	tag_t                  tag_s3;

	assign busy      = state_q != ST_IDLE;
	assign cfg_ready = !busy;

	assign pair_ok_w = 32'(point_a) < MAX_POINTS && 32'(point_b) < MAX_POINTS;
	assign slot_ok_w = 32'(slot) < MAX_FACILITIES && 32'(facility_point) < MAX_POINTS;
	assign p_last_w  = p_q == np_last_q;
	assign f_last_w  = f_q == nf_last_q;

	always_comb begin
		if (32'(point_count_q) > MAX_POINTS) begin
			np_last_w = PW'(MAX_POINTS - 1);
		end else begin
			np_last_w = PW'(point_count_q - PC_W'(1));
		end
		if (facility_count_q == '0) begin
			nf_last_w = '0;
		end else if (32'(facility_count_q) > MAX_FACILITIES) begin
			nf_last_w = SW'(MAX_FACILITIES - 1);
		end else begin
			nf_last_w = SW'(facility_count_q - FC_W'(1));
		end
	end

	always_comb begin
		state_nxt = state_q;
		iss_vld   = 1'b0;
		iss_tag   = '0;
		iss_a     = p_q;
		iss_b     = slots_q[f_q];
		acc_ctl   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_WRITE: begin
							if (pair_ok_w) begin
								iss_vld    = 1'b1;
								iss_tag.wr = 1'b1;
								iss_a      = PW'(point_a);
								iss_b      = PW'(point_b);
								state_nxt  = ST_WRITE;
							end
						end
						MODE_EVAL: begin
							acc_ctl.start = 1'b1;
							if (point_count_q == '0) begin
								acc_ctl.empty_fin = 1'b1;
								state_nxt         = ST_WAIT;
							end else begin
								state_nxt = ST_ISSUE;
							end
						end
						MODE_CLEAR: begin
							acc_ctl.clear_best = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ISSUE: begin
				iss_vld         = 1'b1;
				iss_tag.first_f = f_q == '0;
				iss_tag.last_f  = f_last_w;
				iss_tag.last_p  = p_last_w;
				if (f_last_w && p_last_w) begin
					state_nxt = ST_WAIT;
				end
			end
			ST_WRITE: begin
				if (tri_vld) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			point_count_q    <= PC_RESET;
			facility_count_q <= FC_RESET;
			vld_s3           <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s3  <= tri_vld && !tri_tag.wr;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POINT_COUNT:    point_count_q    <= cfg_data[PC_W-1:0];
					REG_FACILITY_COUNT: facility_count_q <= cfg_data[FC_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tri_tag;
		if (state_q == ST_IDLE && start) begin
			if (mode == MODE_WRITE) begin
				wdata_q <= DIST_WIDTH'(distance_value);
			end
			if (mode == MODE_SET && slot_ok_w) begin
				slots_q[SW'(slot)] <= PW'(facility_point);
			end
			if (mode == MODE_EVAL) begin
				p_q       <= '0;
				f_q       <= '0;
				np_last_q <= np_last_w;
				nf_last_q <= nf_last_w;
			end
		end
		// advance facility first, then point
		if (state_q == ST_ISSUE) begin
			if (f_last_w) begin
				f_q <= '0;
				p_q <= p_q + PW'(1);
			end else begin
				f_q <= f_q + SW'(1);
			end
		end
	end

	pmce_tri_addr #(
		.MAX_POINTS(MAX_POINTS)
	) u_tri_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (iss_vld),
		.in_tag (iss_tag),
		.a      (iss_a),
		.b      (iss_b),
		.out_vld(tri_vld),
		.out_tag(tri_tag),
		.addr   (tri_addr)
	);

	pmce_dist_mem #(
		.MAX_POINTS(MAX_POINTS),
		.DIST_WIDTH(DIST_WIDTH)
	) u_dist_mem (
		.clk  (clk),
		.we   (tri_vld && tri_tag.wr),
		.waddr(tri_addr),
		.wdata(wdata_q),
		.re   (tri_vld && !tri_tag.wr),
		.raddr(tri_addr),
		.rdata(rd_data)
	);

	pmce_accum #(
		.DIST_WIDTH(DIST_WIDTH)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (acc_ctl),
		.rd_vld   (vld_s3),
		.rd_tag   (tag_s3),
		.rd_data  (rd_data),
		.done     (done),
		.cost     (cost),
		.improved (improved),
		.best_cost(best_cost)
	);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside an evaluation");

	a_improved_sets_best: assert property (@(posedge clk) disable iff (!arst_n)
		done && improved |-> best_cost == cost)
		else $error("improved result did not replace the best cost");

	a_best_not_above_cost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> best_cost <= cost)
		else $error("best cost above reported cost");

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !vld_s3)
		else $error("table read in flight while idle");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import pmce_pkg::*;

	localparam int LIMIT = 5_000_000;
	localparam logic [COST_W-1:0] COST_MAX = '1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
	// candidate facility sites; every row is preloaded against each of them
	localparam logic [9:0] SITES [8] = '{10'd0, 10'd1, 10'd341, 10'd512,
		10'd700, 10'd1000, 10'd1022, 10'd1023};

	typedef enum {ROW_CMD, ROW_CFG} row_kind_e;

	typedef struct {
		logic [1:0]  mode;
		logic [9:0]  pa;
		logic [9:0]  pb;
		logic [31:0] dval;
		logic [2:0]  sl;
		logic [9:0]  fp;
	} cmd_t;

	typedef struct {
		logic [COST_W-1:0] cost;
		logic              imp;
		logic [COST_W-1:0] best;
	} eval_res_t;

	typedef struct {
		row_kind_e             kind;
		cmd_t                  c;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    known;
		eval_res_t             res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic [9:0] point_a;
	logic [9:0] point_b;
	logic [31:0] distance_value;
	logic [2:0] slot;
	logic [9:0] facility_point;
	logic done;
	logic [COST_W-1:0] cost;
	logic improved;
	logic [COST_W-1:0] best_cost;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow state of the block
	logic [31:0] dist_tab [longint unsigned];
	logic [9:0] slot_pt [8];
	bit slot_ok [8];
	logic [COST_W-1:0] best_model = '1;
	logic [PC_W-1:0] pc_model = PC_RESET;
	logic [FC_W-1:0] fc_model = FC_RESET;

	eval_res_t pending [$];
	eval_res_t want;
	eval_res_t no_res = '{default: '0};
	dir_row_t plan [$];
	int err_cnt = 0;
	int cyc = 0;
	bit quiet = 1'b0;

	p_median_cost_evaluator_core DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint unsigned pair_addr(input logic [9:0] a, input logic [9:0] b);
		longint unsigned hi;
		longint unsigned lo;
		hi = (a >= b) ? a : b;
		lo = (a >= b) ? b : a;
		return hi * (hi + 1) / 2 + lo;
	endfunction

	function automatic logic [31:0] table_read(input logic [9:0] a, input logic [9:0] b);
		longint unsigned k;
		k = pair_addr(a, b);
		return dist_tab.exists(k) ? dist_tab[k] : 32'd0;
	endfunction

	function automatic int eff_points();
		return (pc_model > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(pc_model);
	endfunction

	function automatic int eff_facs();
		if (fc_model == 0)
			return 1;
		return (fc_model > MAX_FAC_DEF) ? MAX_FAC_DEF : int'(fc_model);
	endfunction

	function automatic eval_res_t run_eval();
		eval_res_t r;
		logic [63:0] total;
		logic [31:0] near;
		logic [31:0] d;
		total = 0;
		for (int p = 0; p < eff_points(); p++) begin
			near = table_read(10'(p), slot_pt[0]);
			for (int f = 1; f < eff_facs(); f++) begin
				d = table_read(10'(p), slot_pt[f]);
				if (d < near)
					near = d;
			end
			total += near;
			if (total > COST_MAX)
				total = COST_MAX;
		end
		r.cost = total[COST_W-1:0];
		r.imp = (r.cost < best_model);
		if (r.imp)
			best_model = r.cost;
		r.best = best_model;
		return r;
	endfunction

	// returns 1 when the command produces a result
	function automatic bit model_step(input cmd_t c, output eval_res_t r);
		r = no_res;
		case (c.mode)
			MODE_WRITE: begin
				dist_tab[pair_addr(c.pa, c.pb)] = c.dval;
				return 1'b0;
			end
			MODE_SET: begin
				slot_pt[c.sl] = c.fp;
				slot_ok[c.sl] = 1'b1;
				return 1'b0;
			end
			MODE_CLEAR: begin
				best_model = '1;
				return 1'b0;
			end
			default: begin
				r = run_eval();
				return 1'b1;
			end
		endcase
	endfunction

	function automatic bit slot_usable(input int f);
		if (!slot_ok[f])
			return 1'b0;
		for (int p = 0; p < eff_points(); p++)
			if (!dist_tab.exists(pair_addr(10'(p), slot_pt[f])))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic cmd_t mk_cmd(input logic [1:0] md, input logic [9:0] pa,
		input logic [9:0] pb, input logic [31:0] dval, input logic [2:0] sl,
		input logic [9:0] fp);
		cmd_t c;
		c.mode = md;
		c.pa = pa;
		c.pb = pb;
		c.dval = dval;
		c.sl = sl;
		c.fp = fp;
		return c;
	endfunction

	function automatic dir_row_t cmd_row(input cmd_t c);
		dir_row_t r;
		r.kind = ROW_CMD;
		r.c = c;
		r.idx = '0;
		r.data = '0;
		r.known = 1'b0;
		r.res = no_res;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		dir_row_t r;
		r = cmd_row(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0));
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic dir_row_t known_eval(input logic [COST_W-1:0] c, input logic imp,
		input logic [COST_W-1:0] b);
		dir_row_t r;
		r = cmd_row(mk_cmd(MODE_EVAL, 0, 0, 0, 0, 0));
		r.known = 1'b1;
		r.res.cost = c;
		r.res.imp = imp;
		r.res.best = b;
		return r;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		logic [9:0] t;
		c = mk_cmd(2'($urandom), 10'($urandom), 10'($urandom), $urandom, 3'($urandom),
			10'($urandom));
		k = $urandom_range(99);
		if (k < 40) begin
			c.mode = MODE_WRITE;
			if ($urandom_range(9) < 7) begin
				c.pa = SITES[$urandom_range(7)];
				if ($urandom_range(1) == 1) begin
					t = c.pa;
					c.pa = c.pb;
					c.pb = t;
				end
			end
			case ($urandom_range(15))
				0: c.dval = 32'd0;
				1: c.dval = 32'hFFFF_FFFF;
				default: ;
			endcase
		end else if (k < 65) begin
			c.mode = MODE_SET;
			if ($urandom_range(99) < 85)
				c.fp = SITES[$urandom_range(7)];
		end else if (k < 90) begin
			c.mode = MODE_EVAL;
		end else begin
			c.mode = MODE_CLEAR;
		end
		return c;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_points();
		case ($urandom_range(19))
			0: return '0;
			1: return 11'd1024;
			2: return 11'($urandom_range(1025, 2047));
			default: return 11'($urandom_range(1, 48));
		endcase
	endfunction

	task automatic issue(input cmd_t c, input bit known, input eval_res_t typed);
		eval_res_t r;
		while (!quiet && $urandom_range(99) < 31) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= c.mode;
		point_a <= c.pa;
		point_b <= c.pb;
		distance_value <= c.dval;
		slot <= c.sl;
		facility_point <= c.fp;
		do
			@(posedge clk);
		while (busy);
		if (model_step(c, r))
			pending.push_back(known ? typed : r);
	endtask

	// drop start, drain all results, then let a distance write finish
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		while (!quiet && $urandom_range(99) < 31)
			@(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_POINT_COUNT)
			pc_model = data;
		else if (idx == REG_FACILITY_COUNT)
			fc_model = data[FC_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// put a fully preloaded site into every slot the next evaluation reads that lacks one
	task automatic repair_slots();
		for (int f = 0; f < eff_facs(); f++)
			if (!slot_usable(f))
				issue(mk_cmd(MODE_SET, 10'($urandom), 10'($urandom), $urandom, 3'(f),
					SITES[$urandom_range(7)]), 1'b0, no_res);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%0t: result with none expected, cost %h", $time, cost);
				err_cnt++;
			end else begin
				want = pending.pop_front();
				if (cost !== want.cost) begin
					$display("%0t: cost expected %h, got %h", $time, want.cost, cost);
					err_cnt++;
				end
				if (improved !== want.imp) begin
					$display("%0t: improved expected %b, got %b", $time, want.imp, improved);
					err_cnt++;
				end
				if (best_cost !== want.best) begin
					$display("%0t: best_cost expected %h, got %h", $time, want.best,
						best_cost);
					err_cnt++;
				end
			end
		end
	end

	initial begin : stim
		cmd_t c;
		logic [9:0] a;
		logic [31:0] dv;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_WRITE;
		point_a = '0;
		point_b = '0;
		distance_value = '0;
		slot = '0;
		facility_point = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every row against each candidate site
		for (int p = 0; p < MAX_POINTS_DEF; p++) begin
			for (int s = 0; s < 8; s++) begin
				if (!dist_tab.exists(pair_addr(10'(p), SITES[s]))) begin
					a = 10'(p);
					dv = $urandom;
					if ($urandom_range(31) == 0)
						dv = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'd0;
					if ($urandom_range(1) == 1)
						c = mk_cmd(MODE_WRITE, a, SITES[s], dv, 3'($urandom), 10'($urandom));
					else
						c = mk_cmd(MODE_WRITE, SITES[s], a, dv, 3'($urandom), 10'($urandom));
					issue(c, 1'b0, no_res);
				end
			end
		end

		// zero points: cost is zero, so the first one beats the reset best
		plan.push_back(cfg_row(REG_POINT_COUNT, 11'd0));
		plan.push_back(known_eval(48'd0, 1'b1, 48'd0));
		plan.push_back(known_eval(48'd0, 1'b0, 48'd0));
		plan.push_back(cmd_row(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0)));
		plan.push_back(known_eval(48'd0, 1'b1, 48'd0));
		plan.push_back(cfg_row(REG_SPARE_LO, 11'h7FF));
		plan.push_back(cfg_row(REG_SPARE_HI, 11'h000));
		plan.push_back(known_eval(48'd0, 1'b0, 48'd0));
		for (int s = 0; s < 8; s++)
			plan.push_back(cmd_row(mk_cmd(MODE_SET, 0, 0, 0, 3'(s), SITES[7 - s])));
		plan.push_back(cmd_row(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0)));
		plan.push_back(cfg_row(REG_POINT_COUNT, 11'd1024));
		plan.push_back(cfg_row(REG_FACILITY_COUNT, 11'd0));
		plan.push_back(cmd_row(mk_cmd(MODE_EVAL, 0, 0, 0, 0, 0)));
		plan.push_back(cfg_row(REG_FACILITY_COUNT, 11'd15));
		plan.push_back(cfg_row(REG_POINT_COUNT, 11'd2047));
		plan.push_back(cmd_row(mk_cmd(MODE_EVAL, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 3'd7,
			10'h3FF)));
		plan.push_back(cmd_row(mk_cmd(MODE_WRITE, 10'd1023, 10'd0, 32'hFFFF_FFFF, 0, 0)));
		plan.push_back(cmd_row(mk_cmd(MODE_WRITE, 10'd0, 10'd0, 32'd0, 0, 0)));
		plan.push_back(cmd_row(mk_cmd(MODE_WRITE, 10'd512, 10'd1023, 32'h8000_0000, 0, 0)));
		plan.push_back(cfg_row(REG_FACILITY_COUNT, 11'd8));
		plan.push_back(cfg_row(REG_POINT_COUNT, 11'd1));
		plan.push_back(cmd_row(mk_cmd(MODE_EVAL, 0, 0, 0, 0, 0)));
		plan.push_back(cfg_row(REG_POINT_COUNT, 11'd1024));
		plan.push_back(cmd_row(mk_cmd(MODE_EVAL, 0, 0, 0, 0, 0)));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				cfg_write(plan[i].idx, plan[i].data);
			else
				issue(plan[i].c, plan[i].known, plan[i].res);
		end

		for (int i = 0; i < 100; i++) begin
			quiet = (i >= 40 && i < 70);
			if (i % 20 == 0) begin
				cfg_write(REG_POINT_COUNT, pick_points());
				cfg_write(REG_FACILITY_COUNT, 11'($urandom_range(15)));
				if ($urandom_range(2) == 0)
					cfg_write(4'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 11'($urandom));
			end
			c = rand_cmd();
			if (c.mode == MODE_EVAL)
				repair_slots();
			issue(c, 1'b0, no_res);
		end
		quiet = 1'b0;

		settle();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
design/pmce_pkg.sv
design/pmce_tri_addr.sv
design/pmce_dist_mem.sv
design/pmce_accum.sv
design/p_median_cost_evaluator_core.sv
tb/sv/tb.sv
